@@ src/fssm_pkg.sv @@
// package: micro-operation types, microprogram and face table of the safety monitor
`default_nettype none
package fssm_pkg;

  localparam int unsigned REG_AW    = 5;
  localparam int unsigned FACE_ROWS = 64;
  localparam int unsigned UC_LEN    = 98;
  localparam int unsigned UC_AW     = 7;

  localparam logic signed [31:0] Q_ONE = 32'sd1048576;
  localparam logic signed [31:0] VMAX  = 32'sd3145728;

  // register file map
  localparam logic [REG_AW-1:0] R_S0   = 5'd0;
  localparam logic [REG_AW-1:0] R_S1   = 5'd1;
  localparam logic [REG_AW-1:0] R_S2   = 5'd2;
  localparam logic [REG_AW-1:0] R_S3   = 5'd3;
  localparam logic [REG_AW-1:0] R_S4   = 5'd4;
  localparam logic [REG_AW-1:0] R_S5   = 5'd5;
  localparam logic [REG_AW-1:0] R_ERR  = 5'd6;
  localparam logic [REG_AW-1:0] R_U1   = 5'd7;
  localparam logic [REG_AW-1:0] R_U2   = 5'd8;
  localparam logic [REG_AW-1:0] R_TMP  = 5'd9;
  localparam logic [REG_AW-1:0] R_X2   = 5'd10;
  localparam logic [REG_AW-1:0] R_T    = 5'd11;
  localparam logic [REG_AW-1:0] R_SP   = 5'd12;
  localparam logic [REG_AW-1:0] R_CP   = 5'd13;
  localparam logic [REG_AW-1:0] R_SE   = 5'd14;
  localparam logic [REG_AW-1:0] R_CE   = 5'd15;
  localparam logic [REG_AW-1:0] R_DE   = 5'd16;
  localparam logic [REG_AW-1:0] R_DP   = 5'd17;
  localparam logic [REG_AW-1:0] R_DT   = 5'd18;
  localparam logic [REG_AW-1:0] R_USUM = 5'd19;
  localparam logic [REG_AW-1:0] R_UDIF = 5'd20;

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_CLAMP} op_e;
  typedef enum logic [0:0] {A_MEM, A_IMM} asel_e;
  typedef enum logic [1:0] {B_MEM, B_IMM, B_SETP} bsel_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ISSUE, ST_EXEC, ST_WB, ST_FACE, ST_DRAIN, ST_HOLD
  } state_e;

  typedef struct packed {
    op_e                op;
    asel_e              asel;
    bsel_e              bsel;
    logic [REG_AW-1:0]  dst;
    logic [REG_AW-1:0]  ra;
    logic [REG_AW-1:0]  rb;
    logic signed [31:0] imm;
  } uop_t;

  typedef struct packed {
    logic               we;
    logic [REG_AW-1:0]  addr;
    logic signed [31:0] data;
  } wr_t;

  function automatic uop_t u_mi(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a, int imm);
    u_mi = '{op: OP_MUL, asel: A_MEM, bsel: B_IMM, dst: d, ra: a, rb: '0, imm: 32'(imm)};
  endfunction

  function automatic uop_t u_mm(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a,
                                logic [REG_AW-1:0] b);
    u_mm = '{op: OP_MUL, asel: A_MEM, bsel: B_MEM, dst: d, ra: a, rb: b, imm: '0};
  endfunction

  function automatic uop_t u_add(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a,
                                 logic [REG_AW-1:0] b);
    u_add = '{op: OP_ADD, asel: A_MEM, bsel: B_MEM, dst: d, ra: a, rb: b, imm: '0};
  endfunction

  function automatic uop_t u_sub(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a,
                                 logic [REG_AW-1:0] b);
    u_sub = '{op: OP_SUB, asel: A_MEM, bsel: B_MEM, dst: d, ra: a, rb: b, imm: '0};
  endfunction

  // one minus a register
  function automatic uop_t u_osub(logic [REG_AW-1:0] d, logic [REG_AW-1:0] b);
    u_osub = '{op: OP_SUB, asel: A_IMM, bsel: B_MEM, dst: d, ra: '0, rb: b, imm: Q_ONE};
  endfunction

  function automatic uop_t u_clamp(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a);
    u_clamp = '{op: OP_CLAMP, asel: A_MEM, bsel: B_MEM, dst: d, ra: a, rb: '0, imm: '0};
  endfunction

  function automatic uop_t u_setp(logic [REG_AW-1:0] d, logic [REG_AW-1:0] a);
    u_setp = '{op: OP_SUB, asel: A_MEM, bsel: B_SETP, dst: d, ra: a, rb: '0, imm: '0};
  endfunction

  // one euler step: controller, series, dynamics, state update
  localparam uop_t UCODE [UC_LEN] = '{
    u_setp(R_ERR, R_S0),
    u_mi(R_U1, R_ERR, -6815744),
    u_mi(R_TMP, R_S1, 735052),   u_sub(R_U1, R_U1, R_TMP),
    u_mi(R_TMP, R_S3, 2396840),  u_sub(R_U1, R_U1, R_TMP),
    u_mi(R_TMP, R_S4, 159960),   u_sub(R_U1, R_U1, R_TMP),
    u_mi(R_U2, R_ERR, -6815744),
    u_mi(R_TMP, R_S1, 597793),   u_add(R_U2, R_U2, R_TMP),
    u_mi(R_TMP, R_S3, 2398770),  u_sub(R_U2, R_U2, R_TMP),
    u_mi(R_TMP, R_S4, 313000),   u_add(R_U2, R_U2, R_TMP),
    u_clamp(R_U1, R_U1),         u_clamp(R_U2, R_U2),
    u_add(R_USUM, R_U1, R_U2),   u_sub(R_UDIF, R_U1, R_U2),
    // sine of pitch
    u_mm(R_X2, R_S1, R_S1),      u_mi(R_T, R_X2, 14564),    u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 24966),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 52429),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 174763),   u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mm(R_SP, R_S1, R_T),
    // cosine of pitch
    u_mm(R_X2, R_S1, R_S1),      u_mi(R_T, R_X2, 18725),    u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 34953),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 87381),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 524288),   u_mm(R_T, R_TMP, R_T),     u_osub(R_CP, R_T),
    // sine of elevation
    u_mm(R_X2, R_S0, R_S0),      u_mi(R_T, R_X2, 14564),    u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 24966),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 52429),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 174763),   u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mm(R_SE, R_S0, R_T),
    // cosine of elevation
    u_mm(R_X2, R_S0, R_S0),      u_mi(R_T, R_X2, 18725),    u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 34953),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 87381),    u_mm(R_T, R_TMP, R_T),     u_osub(R_T, R_T),
    u_mi(R_TMP, R_X2, 524288),   u_mm(R_T, R_TMP, R_T),     u_osub(R_CE, R_T),
    // accelerations
    u_mi(R_DE, R_CE, -524288),   u_mi(R_TMP, R_SE, -2516582), u_add(R_DE, R_DE, R_TMP),
    u_mi(R_TMP, R_CP, 209715),   u_mm(R_TMP, R_TMP, R_USUM),  u_add(R_DE, R_DE, R_TMP),
    u_mi(R_DP, R_SP, 125829),    u_mi(R_TMP, R_CP, 125829),   u_add(R_DP, R_DP, R_TMP),
    u_mi(R_TMP, R_S4, -2621440), u_add(R_DP, R_DP, R_TMP),
    u_mi(R_TMP, R_UDIF, 2202010), u_add(R_DP, R_DP, R_TMP),
    u_mi(R_DT, R_S5, -20972),    u_mi(R_TMP, R_SP, 10485760),
    u_mm(R_TMP, R_TMP, R_USUM),  u_add(R_DT, R_DT, R_TMP),
    // angles first, they use the old rates
    u_mi(R_TMP, R_S3, 20972),    u_add(R_S0, R_S0, R_TMP),
    u_mi(R_TMP, R_S4, 20972),    u_add(R_S1, R_S1, R_TMP),
    u_mi(R_TMP, R_S5, 20972),    u_add(R_S2, R_S2, R_TMP),
    u_mi(R_TMP, R_DE, 20972),    u_add(R_S3, R_S3, R_TMP),
    u_mi(R_TMP, R_DP, 20972),    u_add(R_S4, R_S4, R_TMP),
    u_mi(R_TMP, R_DT, 20972),    u_add(R_S5, R_S5, R_TMP)
  };

  // face coefficients in units of 1e-6, rows past the list are zero
  localparam logic signed [20:0] FACE_COEF [FACE_ROWS][6] = '{
    0: '{-937749, -347314, 0, 0, 0, 0},
    1: '{1000000, 0, 0, 0, 0, 0},
    2: '{0, 0, 0, 1000000, 0, 0},
    3: '{0, 0, 0, 0, 1000000, 0},
    4: '{-937749, 347314, 0, 0, 0, 0},
    5: '{-1000000, 0, 0, 0, 0, 0},
    6: '{0, 0, 0, -1000000, 0, 0},
    7: '{0, 0, 0, 0, -1000000, 0},
    8: '{-920831, 341049, 0, -184166, 42875, 0},
    9: '{980581, 0, 0, 196116, 0, 0},
    10: '{976164, 92968, 0, 195233, 18594, 0},
    11: '{976164, -92968, 0, 195233, -18594, 0},
    12: '{982846, 26635, 0, 182186, 10654, 0},
    13: '{983313, 33791, 0, 178416, 11006, 0},
    14: '{-980581, 0, 0, -196116, 0, 0},
    15: '{-942434, -177818, 0, -280952, -35564, 0},
    16: '{-920831, -341049, 0, -184166, -42875, 0},
    17: '{-939588, 229568, 0, -251069, 37920, 0},
    18: '{-929818, 247341, 0, -269327, 41529, 0},
    19: '{-945071, 207015, 0, -250444, 35553, 0},
    20: '{730320, -429600, 0, 524112, -85920, 0},
    21: '{730320, 429600, 0, 524112, 85920, 0},
    22: '{983313, -33791, 0, 178416, -11006, 0},
    23: '{982846, -26635, 0, 182186, -10654, 0},
    24: '{-919538, -340570, 0, -183908, -68114, 0},
    25: '{-929818, -247341, 0, -269327, -41529, 0},
    26: '{-945071, -207015, 0, -250444, -35553, 0},
    27: '{-924294, 88028, 0, -369718, 35211, 0},
    28: '{-942434, 177818, 0, -280952, 35564, 0},
    29: '{-976164, 92968, 0, -195233, 18594, 0},
    30: '{-942675, 223627, 0, -244964, 36715, 0},
    31: '{-919538, 340570, 0, -183908, 68114, 0},
    32: '{-942675, -223627, 0, -244964, -36715, 0},
    33: '{-939588, -229568, 0, -251069, -37920, 0},
    34: '{-976164, -92968, 0, -195233, -18594, 0},
    35: '{-924294, -88028, 0, -369718, -35211, 0},
    36: '{924294, 88028, 0, 369718, 35211, 0},
    37: '{924294, -88028, 0, 369718, -35211, 0},
    default: '{default: 21'sd0}
  };

  localparam logic [20:0] FACE_BOUND [FACE_ROWS] = '{
    0: 114896, 1: 119671, 2: 199735, 3: 1300000, 4: 114896, 5: 119671,
    6: 199735, 7: 1300000, 8: 164176, 9: 136959, 10: 197136, 11: 197136,
    12: 157410, 13: 160876, 14: 136959, 15: 160740, 16: 164176, 17: 156719,
    18: 165424, 19: 152473, 20: 496346, 21: 496346, 22: 160876, 23: 157410,
    24: 184185, 25: 165424, 26: 152473, 27: 185233, 28: 160740, 29: 137058,
    30: 153904, 31: 184185, 32: 153904, 33: 156719, 34: 137058, 35: 185233,
    36: 242119, 37: 242119,
    default: 21'd0
  };

endpackage
`default_nettype wire

@@ src/fssm_regfile.sv @@
// register file memory: one write port, two registered read ports
`default_nettype none
module fssm_regfile (
  input  wire                          clk_i,
  input  wire fssm_pkg::wr_t           wr_i,
  input  wire [fssm_pkg::REG_AW-1:0]   raddr_a_i,
  input  wire [fssm_pkg::REG_AW-1:0]   raddr_b_i,
  output logic signed [31:0]           rdata_a_o,
  output logic signed [31:0]           rdata_b_o
);
  import fssm_pkg::*;

  logic signed [31:0] mem [2**REG_AW];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

@@ src/forward_sim_safety_monitor_top.sv @@
// top level: microcoded forward simulation and polytope check over a register file
// each request loads its six inputs, then every step issues, executes and writes back the 98
// micro-ops and checks NUM_FACES faces term by term, for up to HORIZON_STEPS steps
// one request at a time; rate set by the shared micro-op multiplier/alu and one read per face term
// reset: setpoint returns to 0.4 rad and control goes idle; register file is loaded before use
`default_nettype none
module forward_sim_safety_monitor_top #(
  parameter int unsigned HORIZON_STEPS = 50,
  parameter int unsigned NUM_FACES     = 52
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire signed [31:0]   elevation_i,
  input  wire signed [31:0]   pitch_i,
  input  wire signed [31:0]   travel_i,
  input  wire signed [31:0]   elevation_rate_i,
  input  wire signed [31:0]   pitch_rate_i,
  input  wire signed [31:0]   travel_rate_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                recoverable_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fssm_pkg::*;

  state_e state_q, state_d;

  logic [UC_AW-1:0]   pc_q;
  logic [2:0]         ld_q;
  logic [7:0]         step_q;
  logic [5:0]         fk_q, k1_q, k2_q;
  logic [2:0]         fi_q, i1_q, i2_q;
  logic               v1_q, v2_q;
  logic signed [52:0] fprod_q;
  logic signed [55:0] acc_q;
  logic               viol_q;
  logic signed [63:0] mprod_q;
  logic signed [31:0] alu_q;
  logic signed [31:0] in_q [6];
  logic signed [22:0] setp_q;
  logic               out_valid_q;
  logic               result_q;

  uop_t               uop;
  wr_t                wr;
  logic [REG_AW-1:0]  raddr_a, raddr_b;
  logic signed [31:0] rd_a, rd_b;
  logic signed [31:0] op_a, op_b, setp_ext, alu_d, mul_res;
  logic signed [32:0] sum33;
  logic signed [63:0] mround;
  logic signed [55:0] acc_new, bound_ext;
  logic               uc_last, face_last, drained, finish;

  assign uop      = UCODE[pc_q];
  assign setp_ext = 32'(setp_q);
  assign uc_last  = (pc_q == UC_AW'(UC_LEN - 1));
  assign face_last = (fk_q == 6'(NUM_FACES - 1)) && (fi_q == 3'd5);
  assign drained  = !v1_q && !v2_q;
  assign finish   = viol_q || (step_q == 8'(HORIZON_STEPS - 1));

  // apb
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) begin
      prdata = 32'(setp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setp_q <= 23'sd419430;
    end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
      setp_q <= pwdata[22:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:  if (ld_q == 3'd5) state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_WB;
      ST_WB:    state_d = uc_last ? ST_FACE : ST_ISSUE;
      ST_FACE:  if (face_last) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (drained) begin
          if (!finish) state_d = ST_ISSUE;
          else if (out_valid_q) state_d = ST_HOLD;
          else state_d = ST_IDLE;
        end
      end
      ST_HOLD:  if (!out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath selection
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    raddr_a    = (state_q == ST_FACE) ? REG_AW'(fi_q) : uop.ra;
    raddr_b    = uop.rb;

    op_a = (uop.asel == A_IMM) ? uop.imm : rd_a;
    case (uop.bsel)
      B_MEM:   op_b = rd_b;
      B_IMM:   op_b = uop.imm;
      B_SETP:  op_b = setp_ext;
      default: op_b = rd_b;
    endcase

    alu_d = op_a;
    sum33 = '0;
    case (uop.op)
      OP_ADD: begin
        sum33 = 33'(op_a) + 33'(op_b);
        alu_d = sum33[31:0];
      end
      OP_SUB: begin
        sum33 = 33'(op_a) - 33'(op_b);
        alu_d = sum33[31:0];
      end
      OP_CLAMP: begin
        if (op_a > VMAX) alu_d = VMAX;
        else if (op_a < -VMAX) alu_d = -VMAX;
        else alu_d = op_a;
      end
      default: alu_d = op_a;
    endcase
    // saturate the add or subtract
    if ((uop.op == OP_ADD || uop.op == OP_SUB) && (sum33[32] != sum33[31])) begin
      alu_d = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end

    // round half up, floor shift, saturate
    mround = (mprod_q + 64'sd524288) >>> 20;
    if (mround > 64'sd2147483647) mul_res = 32'sh7fff_ffff;
    else if (mround < -64'sd2147483648) mul_res = 32'sh8000_0000;
    else mul_res = mround[31:0];

    wr = '{we: 1'b0, addr: '0, data: '0};
    if (state_q == ST_LOAD) begin
      wr = '{we: 1'b1, addr: REG_AW'(ld_q), data: in_q[ld_q]};
    end else if (state_q == ST_WB) begin
      wr = '{we: 1'b1, addr: uop.dst, data: (uop.op == OP_MUL) ? mul_res : alu_q};
    end

    acc_new   = ((i2_q == 3'd0) ? 56'sd0 : acc_q) + 56'(fprod_q);
    bound_ext = $signed({15'd0, FACE_BOUND[k2_q], 20'd0});

    out_valid_o   = out_valid_q;
    recoverable_o = result_q;
  end

  fssm_regfile u_regfile (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      in_q[0] <= elevation_i;
      in_q[1] <= pitch_i;
      in_q[2] <= travel_i;
      in_q[3] <= elevation_rate_i;
      in_q[4] <= pitch_rate_i;
      in_q[5] <= travel_rate_i;
    end
    if (state_q == ST_EXEC) begin
      mprod_q <= 64'(op_a) * 64'(op_b);
      alu_q   <= alu_d;
    end
    k1_q    <= fk_q;
    i1_q    <= fi_q;
    k2_q    <= k1_q;
    i2_q    <= i1_q;
    fprod_q <= 53'(FACE_COEF[k1_q][i1_q]) * 53'(rd_a);
    if (v2_q) begin
      acc_q <= acc_new;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      ld_q        <= '0;
      step_q      <= '0;
      fk_q        <= '0;
      fi_q        <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      viol_q      <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == ST_FACE);
      v2_q    <= v1_q;

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          ld_q   <= '0;
          pc_q   <= '0;
          step_q <= '0;
        end
        ST_LOAD: ld_q <= ld_q + 3'd1;
        ST_WB: begin
          if (uc_last) begin
            pc_q   <= '0;
            fk_q   <= '0;
            fi_q   <= '0;
            viol_q <= 1'b0;
          end else begin
            pc_q <= pc_q + UC_AW'(1);
          end
        end
        ST_FACE: begin
          if (fi_q == 3'd5) begin
            fi_q <= '0;
            fk_q <= fk_q + 6'd1;
          end else begin
            fi_q <= fi_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            if (!finish) begin
              step_q <= step_q + 8'd1;
            end else if (!out_valid_q) begin
              out_valid_q <= 1'b1;
              result_q    <= !viol_q;
            end
          end
        end
        ST_HOLD: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            result_q    <= !viol_q;
          end
        end
        default: ;
      endcase

      // last term of a face closes its sum
      if (v2_q && (i2_q == 3'd5) && (acc_new > bound_ext)) begin
        viol_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ test/recovery_checker.sv @@
// checker: predicts the recoverable flag of each accepted request and compares results
module recovery_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] elevation_i,
  input  logic signed [31:0] pitch_i,
  input  logic signed [31:0] travel_i,
  input  logic signed [31:0] elevation_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  input  logic signed [31:0] travel_rate_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               recoverable_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SETPOINT_ADDR = 3'd0;
  localparam int SETPOINT_RESET = 419430;
  localparam int STEPS = 50;
  localparam int USED_ROWS = 38;
  localparam int ONE = 1048576;
  localparam int VLIM = 3145728;

  // polytope rows in units of 1e-6; rows past these are zero and never fire
  localparam int ROW_COEF [USED_ROWS][6] = '{
    '{-937749, -347314, 0, 0, 0, 0}, '{1000000, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1000000, 0, 0}, '{0, 0, 0, 0, 1000000, 0},
    '{-937749, 347314, 0, 0, 0, 0}, '{-1000000, 0, 0, 0, 0, 0},
    '{0, 0, 0, -1000000, 0, 0}, '{0, 0, 0, 0, -1000000, 0},
    '{-920831, 341049, 0, -184166, 42875, 0}, '{980581, 0, 0, 196116, 0, 0},
    '{976164, 92968, 0, 195233, 18594, 0}, '{976164, -92968, 0, 195233, -18594, 0},
    '{982846, 26635, 0, 182186, 10654, 0}, '{983313, 33791, 0, 178416, 11006, 0},
    '{-980581, 0, 0, -196116, 0, 0}, '{-942434, -177818, 0, -280952, -35564, 0},
    '{-920831, -341049, 0, -184166, -42875, 0}, '{-939588, 229568, 0, -251069, 37920, 0},
    '{-929818, 247341, 0, -269327, 41529, 0}, '{-945071, 207015, 0, -250444, 35553, 0},
    '{730320, -429600, 0, 524112, -85920, 0}, '{730320, 429600, 0, 524112, 85920, 0},
    '{983313, -33791, 0, 178416, -11006, 0}, '{982846, -26635, 0, 182186, -10654, 0},
    '{-919538, -340570, 0, -183908, -68114, 0}, '{-929818, -247341, 0, -269327, -41529, 0},
    '{-945071, -207015, 0, -250444, -35553, 0}, '{-924294, 88028, 0, -369718, 35211, 0},
    '{-942434, 177818, 0, -280952, 35564, 0}, '{-976164, 92968, 0, -195233, 18594, 0},
    '{-942675, 223627, 0, -244964, 36715, 0}, '{-919538, 340570, 0, -183908, 68114, 0},
    '{-942675, -223627, 0, -244964, -36715, 0}, '{-939588, -229568, 0, -251069, -37920, 0},
    '{-976164, -92968, 0, -195233, -18594, 0}, '{-924294, -88028, 0, -369718, -35211, 0},
    '{924294, 88028, 0, 369718, 35211, 0}, '{924294, -88028, 0, 369718, -35211, 0}
  };
  localparam int ROW_BOUND [USED_ROWS] = '{
    114896, 119671, 199735, 1300000, 114896, 119671, 199735, 1300000,
    164176, 136959, 197136, 197136, 157410, 160876, 136959, 160740,
    164176, 156719, 165424, 152473, 496346, 496346, 160876, 157410,
    184185, 165424, 152473, 185233, 160740, 137058, 153904, 184185,
    153904, 156719, 137058, 185233, 242119, 242119
  };

  int setpoint;
  bit recoverable_q[$];

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 524288;
    return sat(p >>> 20);
  endfunction

  function automatic int qadd(int a, int b);
    return sat(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(int a, int b);
    return sat(longint'(a) - longint'(b));
  endfunction

  function automatic int qsin(int x);
    int x2, t;
    x2 = qmul(x, x);
    t = qsub(ONE, qmul(x2, 14564));
    t = qsub(ONE, qmul(qmul(x2, 24966), t));
    t = qsub(ONE, qmul(qmul(x2, 52429), t));
    t = qsub(ONE, qmul(qmul(x2, 174763), t));
    return qmul(x, t);
  endfunction

  function automatic int qcos(int x);
    int x2, t;
    x2 = qmul(x, x);
    t = qsub(ONE, qmul(x2, 18725));
    t = qsub(ONE, qmul(qmul(x2, 34953), t));
    t = qsub(ONE, qmul(qmul(x2, 87381), t));
    return qsub(ONE, qmul(qmul(x2, 524288), t));
  endfunction

  function automatic int clip_volt(int v);
    if (v > VLIM) return VLIM;
    if (v < -VLIM) return -VLIM;
    return v;
  endfunction

  function automatic bit predict_recoverable(int s0, int s1, int s2, int s3, int s4,
                                             int s5, int setp);
    int s[6];
    int d[6];
    int err, u1, u2, usum, udif, sp, cp, de, dp, dt;
    longint acc;
    s = '{s0, s1, s2, s3, s4, s5};
    for (int k = 0; k < STEPS; k++) begin
      err = qsub(s[0], setp);
      u1 = qmul(-6815744, err);
      u1 = qsub(u1, qmul(735052, s[1]));
      u1 = qsub(u1, qmul(2396840, s[3]));
      u1 = qsub(u1, qmul(159960, s[4]));
      u2 = qmul(-6815744, err);
      u2 = qadd(u2, qmul(597793, s[1]));
      u2 = qsub(u2, qmul(2398770, s[3]));
      u2 = qadd(u2, qmul(313000, s[4]));
      u1 = clip_volt(u1);
      u2 = clip_volt(u2);
      usum = qadd(u1, u2);
      udif = qsub(u1, u2);
      sp = qsin(s[1]);
      cp = qcos(s[1]);
      de = qadd(qmul(-524288, qcos(s[0])), qmul(-2516582, qsin(s[0])));
      de = qadd(de, qmul(qmul(209715, cp), usum));
      dp = qadd(qmul(125829, sp), qmul(125829, cp));
      dp = qadd(dp, qmul(-2621440, s[4]));
      dp = qadd(dp, qmul(2202010, udif));
      dt = qadd(qmul(-20972, s[5]), qmul(qmul(10485760, sp), usum));
      d = '{s[3], s[4], s[5], de, dp, dt};
      for (int i = 0; i < 6; i++) s[i] = qadd(s[i], qmul(20972, d[i]));
      for (int r = 0; r < USED_ROWS; r++) begin
        acc = 0;
        for (int i = 0; i < 6; i++) acc += longint'(ROW_COEF[r][i]) * longint'(s[i]);
        if (acc > longint'(ROW_BOUND[r]) * ONE) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint = SETPOINT_RESET;
      recoverable_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SETPOINT_ADDR)
        setpoint = int'(signed'(pwdata[22:0]));
      if (in_valid_i && !in_stall_i)
        recoverable_q.push_back(predict_recoverable(elevation_i, pitch_i, travel_i,
          elevation_rate_i, pitch_rate_i, travel_rate_i, setpoint));
      if (out_valid_i && !out_stall_i) begin
        if (recoverable_q.size() == 0) report_mismatch("result with no request waiting");
        else if (recoverable_q[0] !== recoverable_i) begin
          report_mismatch($sformatf("recoverable %b, predicted %b",
                                    recoverable_i, recoverable_q[0]));
          void'(recoverable_q.pop_front());
        end else void'(recoverable_q.pop_front());
      end
      pending = recoverable_q.size();
    end
  end
endmodule

@@ test/testbench.sv @@
// testbench top: drives requests, setpoint writes and result stalls, gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] SETPOINT_ADDR = 3'd0;
  localparam int SP_MAX = 3294199;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] elevation_i = '0, pitch_i = '0, travel_i = '0;
  logic signed [31:0] elevation_rate_i = '0, pitch_rate_i = '0, travel_rate_i = '0;
  logic out_valid_o, recoverable_o;
  logic out_stall_i = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  forward_sim_safety_monitor_top dut (.*);

  recovery_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .elevation_i, .pitch_i, .travel_i, .elevation_rate_i, .pitch_rate_i, .travel_rate_i,
    .out_valid_i(out_valid_o), .out_stall_i, .recoverable_i(recoverable_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (70000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_request(input int e, p, t, er, pr, tr);
    int n;
    n = calm ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elevation_i <= e;
    pitch_i <= p;
    travel_i <= t;
    elevation_rate_i <= er;
    pitch_rate_i <= pr;
    travel_rate_i <= tr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_setpoint(input int v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= SETPOINT_ADDR;
    pwdata <= v;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int small_val(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly states near equilibrium so the horizon runs long, rest anything
  task automatic random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7)
        send_request(small_val(110000), small_val(320000), small_val(2097152),
                     small_val(160000), small_val(200000), small_val(500000));
      else
        send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rest, setpoint state, a small mix, all extremes and -1, each field alone at its extremes, travel pair
    send_request(0, 0, 0, 0, 0, 0);
    send_request(419430, 0, 0, 0, 0, 0);
    send_request(50000, 10000, -300000, 1000, -2000, 5000);
    send_request(mx, mx, mx, mx, mx, mx);
    send_request(mn, mn, mn, mn, mn, mn);
    send_request(-1, -1, -1, -1, -1, -1);
    send_request(mx, 0, 0, 0, 0, 0);
    send_request(mn, 0, 0, 0, 0, 0);
    send_request(0, mx, 0, 0, 0, 0);
    send_request(0, mn, 0, 0, 0, 0);
    send_request(0, 0, mx, 0, 0, 0);
    send_request(0, 0, mn, 0, 0, 0);
    send_request(0, 0, 0, mx, 0, 0);
    send_request(0, 0, 0, mn, 0, 0);
    send_request(0, 0, 0, 0, mx, 0);
    send_request(0, 0, 0, 0, mn, 0);
    send_request(0, 0, 0, 0, 0, mx);
    send_request(0, 0, 0, 0, 0, mn);
    send_request(0, 0, mx, 0, 0, mx);

    // long result hold while requests keep coming
    hold_req = 1'b1;
    random_requests(40);

    write_setpoint(SP_MAX);
    random_requests(15);
    write_setpoint(-SP_MAX);
    random_requests(15);
    // upper bits beyond the register width are ignored
    write_setpoint({9'($urandom_range(0, 511)), 23'd0});
    random_requests(15);
    write_setpoint(104857);
    random_requests(15);

    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ forward_sim_safety_monitor_top.f @@
src/fssm_pkg.sv
src/fssm_regfile.sv
src/forward_sim_safety_monitor_top.sv
test/recovery_checker.sv
test/testbench.sv
